>>> design/wpgh_pkg.sv
// Package: beat types, register codes and constants of the weighted pose goal heuristic.
package wpgh_pkg;

  typedef struct packed {
    logic [1:0]         mode;
    logic               is_goal;
    logic               valid_req;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] yaw;
  } in_beat_t;

  typedef struct packed {
    logic [30:0] cost;
    logic        saturated;
  } out_beat_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_POSE   = 2'd1,
    MODE_POINT  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_GOAL_X     = 3'd0,
    REG_GOAL_Y     = 3'd1,
    REG_GOAL_Z     = 3'd2,
    REG_WEIGHT_X   = 3'd3,
    REG_WEIGHT_Y   = 3'd4,
    REG_WEIGHT_Z   = 3'd5,
    REG_WEIGHT_ROT = 3'd6
  } reg_e;

  localparam logic signed [35:0] PI_Q29      = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q29  = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q29 = 36'sd843314857;
  localparam logic [30:0]        COST_MAX    = 31'h7FFF_FFFF;
  localparam logic [15:0]        WEIGHT_ONE  = 16'd256;

  function automatic logic signed [33:0] atan_q29(input int i);
    logic signed [33:0] a;
    a = '0;
    case (i)
      0:  a = 34'sd421657428;
      1:  a = 34'sd248918915;
      2:  a = 34'sd131521918;
      3:  a = 34'sd66762579;
      4:  a = 34'sd33510843;
      5:  a = 34'sd16771758;
      6:  a = 34'sd8387925;
      7:  a = 34'sd4194219;
      8:  a = 34'sd2097141;
      9:  a = 34'sd1048575;
      10: a = 34'sd524288;
      11: a = 34'sd262144;
      12: a = 34'sd131072;
      13: a = 34'sd65536;
      14: a = 34'sd32768;
      15: a = 34'sd16384;
      16: a = 34'sd8192;
      17: a = 34'sd4096;
      18: a = 34'sd2048;
      19: a = 34'sd1024;
      20: a = 34'sd512;
      21: a = 34'sd256;
      22: a = 34'sd128;
      23: a = 34'sd64;
      24: a = 34'sd32;
      25: a = 34'sd16;
      26: a = 34'sd8;
      27: a = 34'sd4;
      28: a = 34'sd2;
      29: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> design/weighted_pose_goal_heuristic_core.sv
// Top level: pipelined weighted pose goal heuristic with APB register port.
//
// Usage: the input channel (in_valid_i, in_stall_o, in_data_i) takes one
// projected state per beat; the output channel (out_valid_o, out_stall_i,
// out_data_o) returns one cost beat per input beat, in order.
// Goal, weights and heading weight are to be written over the APB port
// while idle; the block does not enforce this. Throughput: one beat per
// cycle while the input is not stalled. Depth is set by the CORDIC stages
// (one per iteration) and the 32 square root stages (one result bit each).
// The pipeline advances as a whole; a two-entry output queue takes results
// while the receiver stalls, so input is stalled only when the queue is full
// and the head beat is stalled.
// Reset clears all valid bits and the queue, and loads goal 0 and all
// weights 1.0. Goal states, failed projections and mode none or three give
// cost 0 with saturated low; costs above 2^31-1 clip and set saturated.
module weighted_pose_goal_heuristic_core
  import wpgh_pkg::*;
#(
  parameter int COST_SCALE   = 1000,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NC  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int NST = 44 + NC;
  localparam int PW  = 32 + $clog2(COST_SCALE + 1);

  logic signed [31:0] goal_x_q, goal_y_q, goal_z_q;
  logic [15:0]        weight_x_q, weight_y_q, weight_z_q, weight_rot_q;
  logic               cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q     <= '0;
      goal_y_q     <= '0;
      goal_z_q     <= '0;
      weight_x_q   <= WEIGHT_ONE;
      weight_y_q   <= WEIGHT_ONE;
      weight_z_q   <= WEIGHT_ONE;
      weight_rot_q <= WEIGHT_ONE;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_GOAL_X:     goal_x_q     <= pwdata;
        REG_GOAL_Y:     goal_y_q     <= pwdata;
        REG_GOAL_Z:     goal_z_q     <= pwdata;
        REG_WEIGHT_X:   weight_x_q   <= pwdata[15:0];
        REG_WEIGHT_Y:   weight_y_q   <= pwdata[15:0];
        REG_WEIGHT_Z:   weight_z_q   <= pwdata[15:0];
        REG_WEIGHT_ROT: weight_rot_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_GOAL_X:     prdata = goal_x_q;
      REG_GOAL_Y:     prdata = goal_y_q;
      REG_GOAL_Z:     prdata = goal_z_q;
      REG_WEIGHT_X:   prdata = {16'd0, weight_x_q};
      REG_WEIGHT_Y:   prdata = {16'd0, weight_y_q};
      REG_WEIGHT_Z:   prdata = {16'd0, weight_z_q};
      REG_WEIGHT_ROT: prdata = {16'd0, weight_rot_q};
      default:        prdata = '0;
    endcase
  end

  // pipeline control
  logic [1:0] cnt_q, cnt_d;
  logic       en, pop, push;
  logic       vld_q [0:NST-1];

  assign pop        = (cnt_q != 2'd0) & ~out_stall_i;
  assign en         = (cnt_q != 2'd2) | pop;
  assign in_stall_o = ~en;
  assign push       = en & vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // s0: offsets
  logic signed [32:0] dx0_q, dy0_q, dz0_q;
  logic signed [15:0] yaw0_q;
  logic               live0_q, pose0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx0_q   <= {goal_x_q[31], goal_x_q} - {in_data_i.pos_x[31], in_data_i.pos_x};
      dy0_q   <= {goal_y_q[31], goal_y_q} - {in_data_i.pos_y[31], in_data_i.pos_y};
      dz0_q   <= {goal_z_q[31], goal_z_q} - {in_data_i.pos_z[31], in_data_i.pos_z};
      yaw0_q  <= in_data_i.yaw;
      live0_q <= ~in_data_i.is_goal & in_data_i.valid_req &
                 ((in_data_i.mode == MODE_POSE) | (in_data_i.mode == MODE_POINT));
      pose0_q <= (in_data_i.mode == MODE_POSE);
    end
  end

  // s1: magnitudes
  logic [32:0]        ax, ay, az;
  logic [23:0]        m1_q [0:2];
  logic signed [32:0] dx1_q, dy1_q, dx2_q, dy2_q, dx3_q, dy3_q;
  logic signed [15:0] yaw1_q, yaw2_q, yaw3_q;
  logic               live1_q, pose1_q, live2_q, pose2_q, live3_q, pose3_q;

  assign ax = dx0_q[32] ? 33'(-dx0_q) : 33'(dx0_q);
  assign ay = dy0_q[32] ? 33'(-dy0_q) : 33'(dy0_q);
  assign az = dz0_q[32] ? 33'(-dz0_q) : 33'(dz0_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q[0] <= ax[31:8];
      m1_q[1] <= ay[31:8];
      m1_q[2] <= az[31:8];
      dx1_q   <= dx0_q;
      dy1_q   <= dy0_q;
      yaw1_q  <= yaw0_q;
      live1_q <= live0_q;
      pose1_q <= pose0_q;
    end
  end

  // s2: squares
  logic [47:0] mm_q [0:2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) mm_q[k] <= 48'(m1_q[k]) * 48'(m1_q[k]);
      dx2_q   <= dx1_q;
      dy2_q   <= dy1_q;
      yaw2_q  <= yaw1_q;
      live2_q <= live1_q;
      pose2_q <= pose1_q;
    end
  end

  // s3: weighted terms
  logic [63:0] px, py, pz;
  logic [55:0] t_q [0:2];

  assign px = 64'(mm_q[0]) * 64'(weight_x_q);
  assign py = 64'(mm_q[1]) * 64'(weight_y_q);
  assign pz = 64'(mm_q[2]) * 64'(weight_z_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q[0]  <= px[63:8];
      t_q[1]  <= py[63:8];
      t_q[2]  <= pz[63:8];
      dx3_q   <= dx2_q;
      dy3_q   <= dy2_q;
      yaw3_q  <= yaw2_q;
      live3_q <= live2_q;
      pose3_q <= pose2_q;
    end
  end

  // s4: distance sum and CORDIC setup, then one stage per iteration
  logic signed [35:0] cx_q [0:NC];
  logic signed [35:0] cy_q [0:NC];
  logic signed [33:0] cz_q [0:NC];
  logic [57:0]        csum_q [0:NC];
  logic signed [15:0] cyaw_q [0:NC];
  logic               clive_q [0:NC];
  logic               cpose_q [0:NC];
  logic               czero_q [0:NC];
  logic signed [35:0] x3, y3;

  assign x3 = 36'(dx3_q);
  assign y3 = 36'(dy3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      csum_q[0]  <= 58'(t_q[0]) + 58'(t_q[1]) + 58'(t_q[2]);
      cyaw_q[0]  <= yaw3_q;
      clive_q[0] <= live3_q;
      cpose_q[0] <= pose3_q;
      czero_q[0] <= (dx3_q == '0) & (dy3_q == '0);
      if (!x3[35]) begin
        cx_q[0] <= x3;
        cy_q[0] <= y3;
        cz_q[0] <= '0;
      end else if (!y3[35]) begin
        cx_q[0] <= y3;
        cy_q[0] <= -x3;
        cz_q[0] <= 34'(HALF_PI_Q29);
      end else begin
        cx_q[0] <= -y3;
        cy_q[0] <= x3;
        cz_q[0] <= -34'(HALF_PI_Q29);
      end
    end
  end

  for (genvar j = 1; j <= NC; j++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!cy_q[j-1][35]) begin
          cx_q[j] <= cx_q[j-1] + (cy_q[j-1] >>> (j - 1));
          cy_q[j] <= cy_q[j-1] - (cx_q[j-1] >>> (j - 1));
          cz_q[j] <= cz_q[j-1] + atan_q29(j - 1);
        end else begin
          cx_q[j] <= cx_q[j-1] - (cy_q[j-1] >>> (j - 1));
          cy_q[j] <= cy_q[j-1] + (cx_q[j-1] >>> (j - 1));
          cz_q[j] <= cz_q[j-1] - atan_q29(j - 1);
        end
        csum_q[j]  <= csum_q[j-1];
        cyaw_q[j]  <= cyaw_q[j-1];
        clive_q[j] <= clive_q[j-1];
        cpose_q[j] <= cpose_q[j-1];
        czero_q[j] <= czero_q[j-1];
      end
    end
  end

  // h1: wrapped heading error
  logic signed [35:0] g_ang, e_raw, e1_q;
  logic [57:0]        sum1_q, sum2_q, sum3_q, sum4_q;
  logic               live_h1_q, pose_h1_q, live_h2_q, pose_h2_q;
  logic               live_h3_q, pose_h3_q, live_h4_q, pose_h4_q;

  assign g_ang = czero_q[NC] ? 36'sd0 : 36'(cz_q[NC]);
  assign e_raw = g_ang - (36'(cyaw_q[NC]) <<< 16);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (e_raw > PI_Q29)        e1_q <= e_raw - TWO_PI_Q29;
      else if (e_raw <= -PI_Q29) e1_q <= e_raw + TWO_PI_Q29;
      else                       e1_q <= e_raw;
      sum1_q    <= csum_q[NC];
      live_h1_q <= clive_q[NC];
      pose_h1_q <= cpose_q[NC];
    end
  end

  // h2: round the magnitude to unsigned Q2.13
  logic [35:0] ae;
  logic [35:0] ar;
  logic [14:0] r_q;

  assign ae = e1_q[35] ? 36'(-e1_q) : 36'(e1_q);
  assign ar = ae + 36'd32768;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q       <= ar[30:16];
      sum2_q    <= sum1_q;
      live_h2_q <= live_h1_q;
      pose_h2_q <= pose_h1_q;
    end
  end

  // h3, h4: weighted square of heading error
  logic [29:0] rr_q;
  logic [45:0] hp;
  logic [27:0] ht_q;

  assign hp = 46'(rr_q) * 46'(weight_rot_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rr_q      <= 30'(r_q) * 30'(r_q);
      sum3_q    <= sum2_q;
      live_h3_q <= live_h2_q;
      pose_h3_q <= pose_h2_q;
      ht_q      <= hp[45:18];
      sum4_q    <= sum3_q;
      live_h4_q <= live_h3_q;
      pose_h4_q <= pose_h3_q;
    end
  end

  // h5: total, then one square root bit per stage
  logic [63:0] rem_q  [0:32];
  logic [63:0] root_q [0:32];
  logic        slive_q [0:32];
  logic [57:0] total;

  assign total = sum4_q + (pose_h4_q ? 58'(ht_q) : 58'd0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0]   <= {total, 6'd0};
      root_q[0]  <= '0;
      slive_q[0] <= live_h4_q;
    end
  end

  for (genvar j = 1; j <= 32; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (j - 1));
    logic [64:0] trial;
    assign trial = {1'b0, root_q[j-1]} + {1'b0, BIT};
    always_ff @(posedge clk_i) begin
      if (en) begin
        if ({1'b0, rem_q[j-1]} >= trial) begin
          rem_q[j]  <= rem_q[j-1] - trial[63:0];
          root_q[j] <= (root_q[j-1] >> 1) + BIT;
        end else begin
          rem_q[j]  <= rem_q[j-1];
          root_q[j] <= root_q[j-1] >> 1;
        end
        slive_q[j] <= slive_q[j-1];
      end
    end
  end

  // m1: scale, m2: saturate
  logic [PW-1:0] prod_q;
  logic          live_m1_q;
  logic [63:0]   scaled;
  out_beat_t     pipe_q;

  assign scaled = 64'(prod_q >> 11);

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q    <= PW'(root_q[32][31:0]) * PW'(COST_SCALE);
      live_m1_q <= slive_q[32];
      if (!live_m1_q) begin
        pipe_q.cost      <= '0;
        pipe_q.saturated <= 1'b0;
      end else if (scaled > 64'(COST_MAX)) begin
        pipe_q.cost      <= COST_MAX;
        pipe_q.saturated <= 1'b1;
      end else begin
        pipe_q.cost      <= scaled[30:0];
        pipe_q.saturated <= 1'b0;
      end
    end
  end

  // output queue
  out_beat_t ent0_q, ent1_q, ent0_d, ent1_d;

  always_comb begin
    ent0_d = ent0_q;
    ent1_d = ent1_q;
    cnt_d  = cnt_q;
    case ({push, pop})
      2'b10: begin
        if (cnt_q == 2'd0) ent0_d = pipe_q;
        else               ent1_d = pipe_q;
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        ent0_d = ent1_q;
        cnt_d  = cnt_q - 2'd1;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          ent0_d = pipe_q;
        end else begin
          ent0_d = ent1_q;
          ent1_d = pipe_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 2'd0;
    else         cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent0_q;

endmodule

>>> design/wpgh_checker.sv
// Checker: port-level assertions for the heuristic core, bound to the top level.
module wpgh_checker
  import wpgh_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output not blocked");

  a_sat_clips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |-> (out_data_o.cost == COST_MAX))
    else $error("saturated beat without maximum cost");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("output beat changed while stalled");

endmodule

bind weighted_pose_goal_heuristic_core wpgh_checker u_wpgh_checker (.*);

>>> bench/wpgh_checker.sv
// Checker: watches both channels and the register port, predicts each cost beat and compares.
`timescale 1ns / 100ps
module wpgh_scoreboard
  import wpgh_pkg::*;
#(
  parameter int COST_SCALE   = 1000,
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_data_i,
  input  logic      psel_i,
  input  logic      penable_i,
  input  logic      pwrite_i,
  input  logic      pready_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int        errors_o,
  output int        pending_o
);

  longint goal_x, goal_y, goal_z;
  longint w_x, w_y, w_z, w_rot;
  out_beat_t cost_q[$];

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-(v + 1)) >>> s) + 1);
  endfunction

  function automatic longint unsigned axis_cost(longint d, longint w);
    longint unsigned m;
    m = longint'(d < 0 ? -d : d) >> 8;
    return (m * m * longint'(w)) >> 8;
  endfunction

  function automatic longint atan_entry(int i);
    longint tab[32] = '{421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
      8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768, 16384,
      8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0};
    return tab[i];
  endfunction

  function automatic longint goal_bearing(longint x, longint y);
    longint z, t, xs, ys;
    int n;
    z = 0;
    n = CORDIC_STEPS > 32 ? 32 : CORDIC_STEPS;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Q29;
      end else begin
        x = -y; y = t; z = -HALF_PI_Q29;
      end
    end
    for (int i = 0; i < n; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += atan_entry(i);
      end else begin
        x = x - ys; y = y + xs; z -= atan_entry(i);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_beat_t predict_cost(in_beat_t b);
    out_beat_t o;
    longint dx, dy, dz, e, r;
    longint unsigned sum, root, c;
    o = '0;
    if (b.is_goal || !b.valid_req || b.mode == MODE_NONE || b.mode == MODE_UNUSED) return o;
    dx = goal_x - longint'(b.pos_x);
    dy = goal_y - longint'(b.pos_y);
    dz = goal_z - longint'(b.pos_z);
    sum = axis_cost(dx, w_x) + axis_cost(dy, w_y) + axis_cost(dz, w_z);
    if (b.mode == MODE_POSE) begin
      e = goal_bearing(dx, dy) - longint'(b.yaw) * 65536;
      while (e > PI_Q29) e -= TWO_PI_Q29;
      while (e <= -PI_Q29) e += TWO_PI_Q29;
      r = ((e < 0 ? -e : e) + 32768) >>> 16;
      sum += (r * r * w_rot) >>> 18;
    end
    root = int_sqrt(sum << 6);
    c = (root * longint'(COST_SCALE)) >> 11;
    if (c > 64'h7FFF_FFFF) begin
      o.cost = COST_MAX;
      o.saturated = 1'b1;
    end else begin
      o.cost = c[30:0];
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t exp_b;
    if (!rst_ni) begin
      goal_x = 0; goal_y = 0; goal_z = 0;
      w_x = 256; w_y = 256; w_z = 256; w_rot = 256;
      cost_q.delete();
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (cost_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_b = cost_q.pop_front();
          if (exp_b.cost !== out_data_i.cost || exp_b.saturated !== out_data_i.saturated) begin
            $display("%0t: mismatch, expected cost %0d sat %0d, actual cost %0d sat %0d",
                     $time, exp_b.cost, exp_b.saturated, out_data_i.cost,
                     out_data_i.saturated);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) cost_q.push_back(predict_cost(in_data_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          REG_GOAL_X:     goal_x = longint'($signed(pwdata_i));
          REG_GOAL_Y:     goal_y = longint'($signed(pwdata_i));
          REG_GOAL_Z:     goal_z = longint'($signed(pwdata_i));
          REG_WEIGHT_X:   w_x = longint'(pwdata_i[15:0]);
          REG_WEIGHT_Y:   w_y = longint'(pwdata_i[15:0]);
          REG_WEIGHT_Z:   w_z = longint'(pwdata_i[15:0]);
          REG_WEIGHT_ROT: w_rot = longint'(pwdata_i[15:0]);
          default: ;
        endcase
      end
      pending_o <= cost_q.size();
    end
  end

endmodule

>>> bench/tb_weighted_pose_goal_heuristic_core.sv
// Testbench top: drives states and register writes, gives the verdict.
`timescale 1ns / 100ps
module tb_weighted_pose_goal_heuristic_core;
  import wpgh_pkg::*;

  localparam int LATENCY = 44 + 16;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_stall_o, out_valid_o, out_stall_i = 0;
  in_beat_t in_data_i = '0;
  out_beat_t out_data_o;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int errors, pending;
  longint cycles = 0;
  logic big_pos;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  weighted_pose_goal_heuristic_core uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o,
    .out_stall_i, .out_data_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  wpgh_scoreboard chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata), .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        n = gap_len();
        out_stall_i <= 1'b1;
        repeat (n + 1) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  task automatic reg_write(reg_e r, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic send_state(in_beat_t b, logic gaps);
    int g;
    if (gaps) begin
      g = gap_len();
      if (g > 0) begin
        in_valid_i <= 0;
        repeat (g) @(negedge clk_i);
      end
    end
    in_valid_i <= 1;
    in_data_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic in_beat_t rand_state();
    in_beat_t b;
    b.mode = $urandom_range(0, 9) < 8 ? 2'($urandom_range(1, 2)) : 2'($urandom_range(0, 3));
    b.is_goal = $urandom_range(0, 15) == 0;
    b.valid_req = $urandom_range(0, 15) != 0;
    if (big_pos) begin
      b.pos_x = $urandom; b.pos_y = $urandom; b.pos_z = $urandom;
    end else begin
      b.pos_x = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      b.pos_y = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      b.pos_z = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    end
    b.yaw = $urandom_range(0, 7) == 0 ? 16'($urandom) :
            16'($signed($urandom_range(0, 51472)) - 25736);
    return b;
  endfunction

  initial begin
    in_beat_t b;
    logic [31:0] dv [8];
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    dv = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000,
           32'h0, 32'h1, 32'hFFFF_FFFF};
    for (int i = 0; i < 8; i++) begin
      b = '0;
      b.valid_req = 1;
      b.mode = (i % 2) ? MODE_POSE : MODE_POINT;
      b.pos_x = dv[i]; b.pos_y = dv[(i + 3) % 8]; b.pos_z = dv[(i + 5) % 8];
      b.yaw = (i == 2) ? 16'sd25736 : (i == 3) ? -16'sd25736 :
              (i == 4) ? 16'h7FFF : (i == 5) ? 16'h8000 : 16'sd0;
      send_state(b, 1'b0);
    end
    b = '0; b.valid_req = 1; b.mode = MODE_NONE; send_state(b, 1'b0);
    b.mode = MODE_UNUSED; send_state(b, 1'b0);
    b.mode = MODE_POSE; b.is_goal = 1; send_state(b, 1'b0);
    b.is_goal = 0; b.valid_req = 0; send_state(b, 1'b0);
    b.valid_req = 1; b.pos_x = 32'h8000_0000; b.pos_y = 32'h8000_0000; send_state(b, 1'b0);
    drain();
    reg_write(REG_GOAL_X, 32'h7FFF_FFFF);
    reg_write(REG_GOAL_Y, 32'h7FFF_FFFF);
    reg_write(REG_GOAL_Z, 32'h7FFF_FFFF);
    reg_write(REG_WEIGHT_X, 32'h0000_FFFF);
    reg_write(REG_WEIGHT_Y, 32'h0000_FFFF);
    reg_write(REG_WEIGHT_Z, 32'h0000_FFFF);
    reg_write(REG_WEIGHT_ROT, 32'h0000_FFFF);
    b = '0; b.valid_req = 1; b.mode = MODE_POSE; b.pos_x = 32'h8000_0000;
    b.pos_y = 32'h8000_0000; b.pos_z = 32'h8000_0000; b.yaw = 16'h8000;
    send_state(b, 1'b0);
    b.mode = MODE_POINT; send_state(b, 1'b0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_GOAL_X, ph == 1 ? 32'h8000_0000 : $urandom);
      reg_write(REG_GOAL_Y, ph == 1 ? 32'h8000_0000 : $urandom);
      reg_write(REG_GOAL_Z, ph == 2 ? 32'h0 : $urandom);
      reg_write(REG_WEIGHT_X, ph == 2 ? 32'h0 : $urandom);
      reg_write(REG_WEIGHT_Y, ph == 3 ? 32'h0000_FFFF : $urandom);
      reg_write(REG_WEIGHT_Z, ph == 3 ? 32'h0 : $urandom);
      reg_write(REG_WEIGHT_ROT, ph == 4 ? 32'h0 : ph == 5 ? 32'h0000_FFFF : $urandom);
      big_pos = 1'(ph % 2);
      for (int k = 0; k < 140; k++) send_state(rand_state(), k > 30);
      in_valid_i <= 0;
      drain();
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
design/wpgh_pkg.sv
design/weighted_pose_goal_heuristic_core.sv
design/wpgh_checker.sv
bench/wpgh_checker.sv
bench/tb_weighted_pose_goal_heuristic_core.sv
